// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/deq_pkg.sv =====
// Constants, types and ring arithmetic for the double-ended queue.
// No dependencies.
package deq_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W      = CNT_W + 1;
  localparam int unsigned OBUF_DEPTH = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [1:0]       occ_t;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DUMP       = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] item_value;
    logic [1:0]               status;
    logic                     last;
  } result_t;

  // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
  function automatic idx_t ring_pos(idx_t base, cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== sv/deq_if.sv =====
// Valid/ready channel interfaces for the queue's request and result beats.
// Depends on deq_pkg.
interface deq_in_if import deq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [2:0]               action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface deq_out_if import deq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] item_value;
  logic [1:0]               status;
  logic                     last;

  modport source (output valid, item_value, status, last, input ready);
  modport sink   (input valid, item_value, status, last, output ready);
endinterface

// ===== sv/deq_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module deq_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== sv/deq_obuf.sv =====
// Two-slot result buffer in front of the output channel.
// Depends on deq_pkg and deq_out_if.
module deq_obuf import deq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  deq_out_if.source out_o,
  output occ_t    occ_o
);

  result_t slot_q [OBUF_DEPTH];
  logic    wr_ptr_q, rd_ptr_q;
  occ_t    cnt_q, cnt_d;
  logic    pop;

  assign pop            = out_o.valid & out_o.ready;
  assign out_o.valid      = (cnt_q != '0);
  assign out_o.item_value = slot_q[rd_ptr_q].item_value;
  assign out_o.status     = slot_q[rd_ptr_q].status;
  assign out_o.last       = slot_q[rd_ptr_q].last;

  // occupancy once this cycle's beat has gone
  assign occ_o = occ_t'(cnt_q - occ_t'(pop));
  assign cnt_d = occ_t'(cnt_q + occ_t'(push_i) - occ_t'(pop));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/double_ended_queue.sv =====
// Bounded double-ended queue of DEPTH signed 32-bit words, held in one RAM ring.
// Push, pop and unknown actions are taken back to back while results drain; a dump
// reads the RAM one entry a cycle while the result buffer has room, and holds the
// input until its last entry is read back, limited by the single read port and the two-slot
// result buffer. Status beats carry item_value zero; a dump ends with last set.
// Depends on deq_pkg, deq_if, deq_ram, deq_obuf and assert_macros.svh.
`include "assert_macros.svh"

module double_ended_queue import deq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  deq_in_if.sink    in_i,
  deq_out_if.source out_o
);

  state_e  state_q, state_d;
  idx_t    front_q, front_d;
  cnt_t    count_q, count_d;
  cnt_t    rd_off_q, rd_off_d;
  logic    rd_pending_q, rd_pending_d;
  logic    rd_last_q, rd_last_d;

  logic              ram_we, ram_re;
  idx_t              ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic    obuf_push;
  result_t obuf_data;
  occ_t    occ;

  logic in_acc, full, empty, rd_space, rd_issue, rd_last;
  idx_t front_dec;

  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign front_dec = ring_pos(front_q, CNT_W'(DEPTH - 1));
  assign rd_space  = occ_t'(occ + occ_t'(rd_pending_q)) < occ_t'(OBUF_DEPTH);
  assign rd_issue  = (state_q == S_DUMP) & rd_space;
  assign rd_last   = (CNT_W'(rd_off_q + CNT_W'(1)) == count_q);

  assign in_i.ready = (state_q == S_IDLE) & ~rd_pending_q & (occ < occ_t'(OBUF_DEPTH));
  assign in_acc     = in_i.valid & in_i.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (action_e'(in_i.action) == ACT_DUMP) && !empty) begin
          state_d = S_DUMP;
        end
      end
      S_DUMP: begin
        if (rd_issue && rd_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    front_d      = front_q;
    count_d      = count_q;
    rd_off_d     = rd_off_q;
    rd_pending_d = 1'b0;
    rd_last_d    = rd_last_q;
    ram_we       = 1'b0;
    ram_waddr    = front_dec;
    ram_re       = 1'b0;
    ram_raddr    = ring_pos(front_q, rd_off_q);
    obuf_push    = 1'b0;
    obuf_data    = '{item_value: '0, status: ST_OK, last: 1'b1};

    if (in_acc) begin
      case (action_e'(in_i.action))
        ACT_PUSH_FRONT: begin
          obuf_push = 1'b1;
          if (full) begin
            obuf_data.status = ST_FULL;
          end else begin
            ram_we  = 1'b1;
            front_d = front_dec;
            count_d = CNT_W'(count_q + CNT_W'(1));
          end
        end
        ACT_PUSH_BACK: begin
          obuf_push = 1'b1;
          if (full) begin
            obuf_data.status = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ring_pos(front_q, count_q);
            count_d   = CNT_W'(count_q + CNT_W'(1));
          end
        end
        ACT_POP_FRONT: begin
          obuf_push = 1'b1;
          if (empty) begin
            obuf_data.status = ST_EMPTY;
          end else begin
            front_d = ring_pos(front_q, CNT_W'(1));
            count_d = CNT_W'(count_q - CNT_W'(1));
          end
        end
        ACT_POP_BACK: begin
          obuf_push = 1'b1;
          if (empty) begin
            obuf_data.status = ST_EMPTY;
          end else begin
            count_d = CNT_W'(count_q - CNT_W'(1));
          end
        end
        ACT_DUMP: begin
          if (empty) begin
            obuf_push        = 1'b1;
            obuf_data.status = ST_EMPTY;
          end else begin
            rd_off_d = '0;
          end
        end
        default: ;
      endcase
    end

    if (rd_issue) begin
      ram_re       = 1'b1;
      rd_off_d     = CNT_W'(rd_off_q + CNT_W'(1));
      rd_pending_d = 1'b1;
      rd_last_d    = rd_last;
    end

    // read data lands in the cycle after issue; input is held off meanwhile
    if (rd_pending_q) begin
      obuf_push            = 1'b1;
      obuf_data.item_value = ram_rdata;
      obuf_data.status     = ST_OK;
      obuf_data.last       = rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      front_q      <= '0;
      count_q      <= '0;
      rd_off_q     <= '0;
      rd_pending_q <= 1'b0;
      rd_last_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      front_q      <= front_d;
      count_q      <= count_d;
      rd_off_q     <= rd_off_d;
      rd_pending_q <= rd_pending_d;
      rd_last_q    <= rd_last_d;
    end
  end

  deq_ram #(
    .DATA_W (DATA_W),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  deq_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (obuf_push),
    .data_i (obuf_data),
    .out_o  (out_o),
    .occ_o  (occ)
  );

  `ASSERT_PROP(a_count_range, count_q <= CNT_W'(DEPTH), "entry count beyond depth")
  `ASSERT_NEVER(a_read_outside_dump, ram_re && (state_q != S_DUMP), "read issued outside dump")
  `ASSERT_NEVER(a_accept_during_read, in_acc && rd_pending_q, "beat taken with read in flight")
  `ASSERT_PROP(a_dump_enters, (in_acc && (in_i.action == ACT_DUMP) && !empty) |=> (state_q == S_DUMP), "dump not started")
  `ASSERT_NEVER(a_obuf_overflow, obuf_push && (occ == occ_t'(OBUF_DEPTH)), "result buffer overrun")

endmodule
